// ===== rtl/core/csmc_pkg.sv =====
// Shared types and constants for the call stack match cache.
`timescale 1ns / 1ps

package csmc_pkg;

    localparam int ADDR_W  = 64;
    localparam int ALLOC_W = 16;
    localparam int TAG_W   = 32;
    localparam int CNT_W   = 32;

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    typedef struct packed {
        logic cmp_en;
        logic clear;
        logic wr_en;
    } slot_ctl_t;

    typedef struct packed {
        logic               cand;
        logic [ALLOC_W-1:0] alloc;
        logic [TAG_W-1:0]   ident;
    } slot_view_t;

endpackage

// ===== rtl/core/csmc_slot.sv =====
// One cache slot: stored stack, tags, running match bit and frame compare.
`timescale 1ns / 1ps

module csmc_slot #(
    parameter int FRAMES_PER_SLOT = 8,
    parameter int PW = $clog2(FRAMES_PER_SLOT + 1),
    parameter int IW = (FRAMES_PER_SLOT > 1) ? $clog2(FRAMES_PER_SLOT) : 1
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  csmc_pkg::slot_ctl_t              ctl,
    input  logic                             live,
    input  logic [PW-1:0]                    pos,
    input  logic [PW-1:0]                    fin_len,
    input  logic [csmc_pkg::ADDR_W-1:0]      addr,
    input  logic [csmc_pkg::ADDR_W-1:0]      wr_frames [FRAMES_PER_SLOT],
    input  logic [csmc_pkg::ALLOC_W-1:0]     wr_alloc,
    input  logic [csmc_pkg::TAG_W-1:0]       wr_ident,
    output csmc_pkg::slot_view_t             view
);
    import csmc_pkg::*;

    logic [ADDR_W-1:0]  frames_reg [FRAMES_PER_SLOT];
    logic [PW-1:0]      len_reg;
    logic [ALLOC_W-1:0] alloc_reg;
    logic [TAG_W-1:0]   ident_reg;
    logic               match_reg;
    logic               match_next;
    logic               match_now;
    logic [ADDR_W-1:0]  frame_rd;

    assign frame_rd  = frames_reg[pos[IW-1:0]];
    assign match_now = match_reg &&
                       (!ctl.cmp_en || (live && (pos < len_reg) && (frame_rd == addr)));

    always_comb
    begin
        match_next = match_reg;
        if (ctl.clear)
            match_next = 1'b1;
        else if (ctl.cmp_en)
            match_next = match_now;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            match_reg <= 1'b1;
        else
            match_reg <= match_next;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            len_reg   <= fin_len;
            alloc_reg <= wr_alloc;
            ident_reg <= wr_ident;
            for (int f = 0; f < FRAMES_PER_SLOT; f++)
                frames_reg[f] <= wr_frames[f];
        end
    end

    assign view.cand  = live && match_now && (len_reg == fin_len);
    assign view.alloc = alloc_reg;
    assign view.ident = ident_reg;

endmodule

// ===== rtl/core/csmc_pick.sv =====
// Lowest-slot priority pick among matching slots.
`timescale 1ns / 1ps

module csmc_pick #(
    parameter int SLOTS = 16
) (
    input  csmc_pkg::slot_view_t          views [SLOTS],
    output logic                          hit,
    output logic [csmc_pkg::ALLOC_W-1:0]  alloc,
    output logic [csmc_pkg::TAG_W-1:0]    ident
);
    import csmc_pkg::*;

    always_comb
    begin
        hit   = 1'b0;
        alloc = '0;
        ident = '0;
        for (int s = SLOTS - 1; s >= 0; s--)
        begin
            if (views[s].cand)
            begin
                hit   = 1'b1;
                alloc = views[s].alloc;
                ident = views[s].ident;
            end
        end
    end

endmodule

// ===== rtl/core/call_stack_match_cache.sv =====
// Top level of the call stack match cache: input register, pending stack, slots, counters.
//
//  port group      dir  handshake            contents
//  start/busy      in   start & !busy        operation, frame_addr, frame_last,
//                                            allocator_tag, entry_tag (one frame)
//  result_valid    out  one-cycle strobe     hit, too_long, found_allocator, found_tag,
//                                            hit_count, miss_count, too_long_count
//
//  One frame is taken every cycle; busy stays low.
//  A lookup result reaches the ports through the input register, which takes its last frame
//  and feeds the parallel slot compare into the result register.
//  Inserts give no result; the written slot is visible to the next stack.
//  Reset clears the fill count, replacement pointer, pending stack state and counters.
//  The receiver cannot stall; a result is shown for exactly one cycle.
`timescale 1ns / 1ps

module call_stack_match_cache #(
    parameter int SLOTS           = 16,
    parameter int FRAMES_PER_SLOT = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic                             operation,
    input  logic [csmc_pkg::ADDR_W-1:0]      frame_addr,
    input  logic                             frame_last,
    input  logic [csmc_pkg::ALLOC_W-1:0]     allocator_tag,
    input  logic [csmc_pkg::TAG_W-1:0]       entry_tag,
    output logic                             result_valid,
    output logic                             hit,
    output logic                             too_long,
    output logic [csmc_pkg::ALLOC_W-1:0]     found_allocator,
    output logic [csmc_pkg::TAG_W-1:0]       found_tag,
    output logic [csmc_pkg::CNT_W-1:0]       hit_count,
    output logic [csmc_pkg::CNT_W-1:0]       miss_count,
    output logic [csmc_pkg::CNT_W-1:0]       too_long_count
);
    import csmc_pkg::*;

    localparam int PW = $clog2(FRAMES_PER_SLOT + 1);
    localparam int IW = (FRAMES_PER_SLOT > 1) ? $clog2(FRAMES_PER_SLOT) : 1;
    localparam int FW = $clog2(SLOTS + 1);
    localparam int SW = $clog2(SLOTS);
    localparam logic [PW-1:0] FRAME_LIMIT = PW'(FRAMES_PER_SLOT);
    localparam logic [FW-1:0] SLOT_LIMIT  = FW'(SLOTS);
    localparam logic [SW-1:0] SLOT_LAST   = SW'(SLOTS - 1);

    logic               in_valid_reg;
    logic               op_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic               last_reg;
    logic [ALLOC_W-1:0] alloc_reg;
    logic [TAG_W-1:0]   tag_reg;

    logic [ADDR_W-1:0]  pending_reg [FRAMES_PER_SLOT];
    logic [PW-1:0]      pos_reg;
    logic               ovf_reg;
    logic [FW-1:0]      filled_reg;
    logic [SW-1:0]      rp_reg;
    logic [CNT_W-1:0]   hits_reg;
    logic [CNT_W-1:0]   misses_reg;
    logic [CNT_W-1:0]   overlong_reg;

    logic               out_valid_reg;
    logic               hit_reg;
    logic               too_long_reg;
    logic [ALLOC_W-1:0] found_alloc_reg;
    logic [TAG_W-1:0]   found_tag_reg;

    logic               step;
    logic               done;
    logic               ins;
    logic               look;
    logic               do_write;
    logic [PW-1:0]      pos_next;
    logic               ovf_next;
    logic [SW-1:0]      tgt;
    logic [ADDR_W-1:0]  wr_frames [FRAMES_PER_SLOT];
    logic               live [SLOTS];
    slot_view_t         views [SLOTS];
    logic               pick_hit;
    logic [ALLOC_W-1:0] pick_alloc;
    logic [TAG_W-1:0]   pick_ident;
    logic               hit_now;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= start;
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            op_reg    <= operation;
            addr_reg  <= frame_addr;
            last_reg  <= frame_last;
            alloc_reg <= allocator_tag;
            tag_reg   <= entry_tag;
        end
    end

    assign step     = in_valid_reg && !ovf_reg && (pos_reg < FRAME_LIMIT);
    assign pos_next = step ? pos_reg + PW'(1) : pos_reg;
    assign ovf_next = ovf_reg || (in_valid_reg && !step);
    assign done     = in_valid_reg && last_reg;
    assign ins      = done && (op_reg == OP_INSERT);
    assign look     = done && (op_reg == OP_LOOKUP);
    assign do_write = ins && !ovf_next;
    assign tgt      = (filled_reg < SLOT_LIMIT) ? filled_reg[SW-1:0] : rp_reg;

    always_comb
    begin
        for (int f = 0; f < FRAMES_PER_SLOT; f++)
            wr_frames[f] = (step && (pos_reg == PW'(f))) ? addr_reg : pending_reg[f];
    end

    always_ff @(posedge clk)
    begin
        if (step)
            pending_reg[pos_reg[IW-1:0]] <= addr_reg;
    end

    for (genvar g = 0; g < SLOTS; g++)
    begin : g_slot
        slot_ctl_t ctl;

        assign live[g]    = FW'(g) < filled_reg;
        assign ctl.cmp_en = step;
        assign ctl.clear  = done;
        assign ctl.wr_en  = do_write && (tgt == SW'(g));

        csmc_slot #(
            .FRAMES_PER_SLOT (FRAMES_PER_SLOT),
            .PW              (PW),
            .IW              (IW)
        ) u_slot (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .live      (live[g]),
            .pos       (pos_reg),
            .fin_len   (pos_next),
            .addr      (addr_reg),
            .wr_frames (wr_frames),
            .wr_alloc  (alloc_reg),
            .wr_ident  (tag_reg),
            .view      (views[g])
        );
    end

    csmc_pick #(
        .SLOTS (SLOTS)
    ) u_pick (
        .views (views),
        .hit   (pick_hit),
        .alloc (pick_alloc),
        .ident (pick_ident)
    );

    assign hit_now = pick_hit && !ovf_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            ovf_reg       <= 1'b0;
            filled_reg    <= '0;
            rp_reg        <= '0;
            hits_reg      <= '0;
            misses_reg    <= '0;
            overlong_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= look;
            if (done)
            begin
                pos_reg <= '0;
                ovf_reg <= 1'b0;
            end
            else if (in_valid_reg)
            begin
                pos_reg <= pos_next;
                ovf_reg <= ovf_next;
            end
            if (do_write)
            begin
                if (filled_reg < SLOT_LIMIT)
                    filled_reg <= filled_reg + FW'(1);
                else
                    rp_reg <= (rp_reg == SLOT_LAST) ? '0 : rp_reg + SW'(1);
            end
            if (look)
            begin
                if (ovf_next)
                    overlong_reg <= overlong_reg + CNT_W'(1);
                else if (hit_now)
                    hits_reg <= hits_reg + CNT_W'(1);
                else
                    misses_reg <= misses_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (look)
        begin
            hit_reg         <= hit_now;
            too_long_reg    <= ovf_next;
            found_alloc_reg <= hit_now ? pick_alloc : '0;
            found_tag_reg   <= hit_now ? pick_ident : '0;
        end
    end

    assign result_valid    = out_valid_reg;
    assign hit             = hit_reg;
    assign too_long        = too_long_reg;
    assign found_allocator = found_alloc_reg;
    assign found_tag       = found_tag_reg;
    assign hit_count       = hits_reg;
    assign miss_count      = misses_reg;
    assign too_long_count  = overlong_reg;

    a_result_from_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> $past(in_valid_reg && last_reg && (op_reg == OP_LOOKUP)))
        else $error("result without a finished lookup");

    a_hit_not_overlong: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(hit_reg && too_long_reg))
        else $error("hit reported on an overlong stack");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        filled_reg <= SLOT_LIMIT)
        else $error("fill count beyond slot count");

    a_replace_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (rp_reg != $past(rp_reg)) |-> ($past(filled_reg) == SLOT_LIMIT))
        else $error("replacement pointer moved before cache filled");

    a_one_count_per_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (CNT_W'(hits_reg + misses_reg + overlong_reg) ==
                           CNT_W'($past(hits_reg + misses_reg + overlong_reg) + CNT_W'(1))))
        else $error("counters did not advance by one for a result");

endmodule

// ===== tb/tb_call_stack_match_cache.sv =====
// Testbench for the call stack match cache: directed and random stacks checked against a predictor.
`timescale 1ns / 1ps

module tb_call_stack_match_cache;

    import csmc_pkg::*;

    localparam int NUM_SLOTS   = 16;
    localparam int SLOT_DEPTH  = 8;
    localparam int MAX_FRAMES  = 12;
    localparam int ITEM_TARGET = 850;
    localparam int QUIET_TAIL  = 120;
    localparam int KNOWN_MAX   = 40;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic [MAX_FRAMES-1:0][ADDR_W-1:0] frames;
        logic [3:0]                        depth;
    } call_stack_t;

    typedef struct packed {
        logic               hit;
        logic               too_long;
        logic [ALLOC_W-1:0] found_allocator;
        logic [TAG_W-1:0]   found_tag;
        logic [CNT_W-1:0]   hit_count;
        logic [CNT_W-1:0]   miss_count;
        logic [CNT_W-1:0]   too_long_count;
    } lookup_result_t;

    class stack_cache_scoreboard;
        logic [ADDR_W-1:0]  slot_frame [NUM_SLOTS][SLOT_DEPTH];
        int unsigned        slot_len [NUM_SLOTS];
        logic [ALLOC_W-1:0] slot_alloc [NUM_SLOTS];
        logic [TAG_W-1:0]   slot_ident [NUM_SLOTS];
        int unsigned        filled;
        int unsigned        victim;
        logic [ADDR_W-1:0]  partial [SLOT_DEPTH];
        int unsigned        partial_len;
        bit                 partial_overlong;
        bit                 still_equal [NUM_SLOTS];
        logic [CNT_W-1:0]   hits;
        logic [CNT_W-1:0]   misses;
        logic [CNT_W-1:0]   overlong;
        lookup_result_t     awaited_lookups [$];
        int                 errors;

        function new();
            filled = 0;
            victim = 0;
            hits = '0;
            misses = '0;
            overlong = '0;
            errors = 0;
            restart_stack();
        endfunction

        function void restart_stack();
            partial_len = 0;
            partial_overlong = 0;
            foreach (still_equal[s])
                still_equal[s] = 1;
        endfunction

        function int outstanding();
            return awaited_lookups.size();
        endfunction

        function void note_frame(logic op, logic [ADDR_W-1:0] addr, logic last,
                                 logic [ALLOC_W-1:0] alloc, logic [TAG_W-1:0] ident);
            lookup_result_t want;
            int unsigned    target;
            if (!partial_overlong && partial_len < SLOT_DEPTH)
            begin
                partial[partial_len] = addr;
                for (int s = 0; s < NUM_SLOTS; s++)
                    if (s >= filled || partial_len >= slot_len[s] ||
                        slot_frame[s][partial_len] != addr)
                        still_equal[s] = 0;
                partial_len++;
            end
            else
                partial_overlong = 1;
            if (!last)
                return;
            if (op == OP_INSERT)
            begin
                if (!partial_overlong)
                begin
                    target = (filled < NUM_SLOTS) ? filled : victim;
                    slot_len[target] = partial_len;
                    slot_alloc[target] = alloc;
                    slot_ident[target] = ident;
                    for (int f = 0; f < partial_len; f++)
                        slot_frame[target][f] = partial[f];
                    if (filled < NUM_SLOTS)
                        filled++;
                    else
                        victim = (victim + 1) % NUM_SLOTS;
                end
                restart_stack();
                return;
            end
            want = '0;
            want.too_long = partial_overlong;
            if (partial_overlong)
                overlong++;
            else
            begin
                for (int s = 0; s < filled; s++)
                    if (!want.hit && still_equal[s] && slot_len[s] == partial_len)
                    begin
                        want.hit = 1;
                        want.found_allocator = slot_alloc[s];
                        want.found_tag = slot_ident[s];
                    end
                if (want.hit)
                    hits++;
                else
                    misses++;
            end
            want.hit_count = hits;
            want.miss_count = misses;
            want.too_long_count = overlong;
            awaited_lookups.push_back(want);
            restart_stack();
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want)
            begin
                $display("%0t mismatch %s expected %h actual %h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_lookup(lookup_result_t got);
            lookup_result_t want;
            if (awaited_lookups.size() == 0)
            begin
                $display("%0t unexpected result expected none actual %h", $time, got);
                errors++;
                return;
            end
            want = awaited_lookups.pop_front();
            compare_field("hit", want.hit, got.hit);
            compare_field("too_long", want.too_long, got.too_long);
            compare_field("found_allocator", want.found_allocator, got.found_allocator);
            compare_field("found_tag", want.found_tag, got.found_tag);
            compare_field("hit_count", want.hit_count, got.hit_count);
            compare_field("miss_count", want.miss_count, got.miss_count);
            compare_field("too_long_count", want.too_long_count, got.too_long_count);
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic               operation = OP_LOOKUP;
    logic [ADDR_W-1:0]  frame_addr = '0;
    logic               frame_last = 1'b0;
    logic [ALLOC_W-1:0] allocator_tag = '0;
    logic [TAG_W-1:0]   entry_tag = '0;
    logic               result_valid;
    logic               hit;
    logic               too_long;
    logic [ALLOC_W-1:0] found_allocator;
    logic [TAG_W-1:0]   found_tag;
    logic [CNT_W-1:0]   hit_count;
    logic [CNT_W-1:0]   miss_count;
    logic [CNT_W-1:0]   too_long_count;

    stack_cache_scoreboard sb;
    logic [ADDR_W-1:0]     addr_pool [8];
    call_stack_t           known_stacks [$];
    bit                    idle_on = 0;
    int                    frames_sent = 0;
    int                    cycle_count = 0;

    call_stack_match_cache #(
        .SLOTS           (NUM_SLOTS),
        .FRAMES_PER_SLOT (SLOT_DEPTH)
    ) dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .operation       (operation),
        .frame_addr      (frame_addr),
        .frame_last      (frame_last),
        .allocator_tag   (allocator_tag),
        .entry_tag       (entry_tag),
        .result_valid    (result_valid),
        .hit             (hit),
        .too_long        (too_long),
        .found_allocator (found_allocator),
        .found_tag       (found_tag),
        .hit_count       (hit_count),
        .miss_count      (miss_count),
        .too_long_count  (too_long_count)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && sb != null)
        begin
            if (start && !busy)
                sb.note_frame(operation, frame_addr, frame_last, allocator_tag, entry_tag);
            if (result_valid)
                sb.check_lookup({hit, too_long, found_allocator, found_tag,
                                 hit_count, miss_count, too_long_count});
        end
    end

    function logic [ADDR_W-1:0] random_addr();
        if ($urandom_range(0, 1) == 0)
            return addr_pool[$urandom_range(0, 7)];
        return {$urandom, $urandom};
    endfunction

    function call_stack_t uniform_stack(int depth, logic [ADDR_W-1:0] addr);
        call_stack_t st;
        st = '0;
        st.depth = 4'(depth);
        for (int i = 0; i < depth; i++)
            st.frames[i] = addr;
        return st;
    endfunction

    function call_stack_t fresh_stack();
        call_stack_t st;
        st = '0;
        st.depth = 4'(($urandom_range(0, 99) < 85) ? $urandom_range(1, SLOT_DEPTH)
                                                   : $urandom_range(SLOT_DEPTH + 1, MAX_FRAMES));
        for (int i = 0; i < st.depth; i++)
            st.frames[i] = random_addr();
        return st;
    endfunction

    task send_frame(logic op, logic [ADDR_W-1:0] addr, logic last,
                    logic [ALLOC_W-1:0] alloc, logic [TAG_W-1:0] ident);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        start <= 1'b1;
        operation <= op;
        frame_addr <= addr;
        frame_last <= last;
        allocator_tag <= alloc;
        entry_tag <= ident;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        frames_sent++;
    endtask

    // only the final frame's operation and tags count; scramble the rest
    task send_stack(call_stack_t st, logic op, logic [ALLOC_W-1:0] alloc,
                    logic [TAG_W-1:0] ident);
        for (int i = 0; i < st.depth - 1; i++)
            send_frame(1'($urandom), st.frames[i], 1'b0, 16'($urandom), $urandom);
        send_frame(op, st.frames[st.depth-1], 1'b1, alloc, ident);
    endtask

    task wait_for_lookups();
        start <= 1'b0;
        @(posedge clk);
        while (sb.outstanding() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        call_stack_t st;
        logic        op;
        bit          drained;
        int          pick;
        sb = new();
        drained = 0;
        addr_pool[0] = '0;
        addr_pool[1] = '1;
        addr_pool[2] = 64'h8000_0000_0000_0000;
        addr_pool[3] = 64'h0000_0000_0000_0001;
        for (int i = 4; i < 8; i++)
            addr_pool[i] = {$urandom, $urandom};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        send_stack(uniform_stack(1, '0), OP_LOOKUP, '1, '1);
        send_stack(uniform_stack(1, '0), OP_INSERT, '1, '1);
        send_stack(uniform_stack(1, '0), OP_LOOKUP, '0, '0);
        send_stack(uniform_stack(SLOT_DEPTH, '1), OP_INSERT, '0, '0);
        send_stack(uniform_stack(SLOT_DEPTH + 1, '1), OP_LOOKUP, '1, '1);
        send_stack(uniform_stack(1, '0), OP_INSERT, 16'h1234, 32'h5678_9abc);
        send_stack(uniform_stack(1, '0), OP_LOOKUP, '0, '0);
        send_stack(uniform_stack(1, '1), OP_LOOKUP, '0, '0);

        while (frames_sent < ITEM_TARGET)
        begin
            if (frames_sent >= ITEM_TARGET - QUIET_TAIL)
                idle_on = 0;
            else if ($urandom_range(0, 9) == 0)
                idle_on = !idle_on;
            if (!drained && frames_sent >= ITEM_TARGET / 2)
            begin
                wait_for_lookups();
                drained = 1;
            end
            op = ($urandom_range(0, 4) < 2) ? OP_INSERT : OP_LOOKUP;
            pick = $urandom_range(0, 99);
            if (known_stacks.size() > 0 && pick < ((op == OP_INSERT) ? 25 : 60))
            begin
                st = known_stacks[$urandom_range(0, known_stacks.size() - 1)];
                case ($urandom_range(0, 9)) inside
                    [0:1]:
                    begin
                        if (st.depth > 1)
                            st.depth--;
                    end
                    [2:3]:
                    begin
                        if (st.depth < MAX_FRAMES)
                        begin
                            st.frames[st.depth] = random_addr();
                            st.depth++;
                        end
                    end
                    4:
                    begin
                        st.frames[st.depth-1] = random_addr();
                    end
                    default:
                    begin
                    end
                endcase
            end
            else
                st = fresh_stack();
            send_stack(st, op, 16'($urandom), $urandom);
            if (op == OP_INSERT && st.depth <= SLOT_DEPTH)
            begin
                known_stacks.push_back(st);
                if (known_stacks.size() > KNOWN_MAX)
                    void'(known_stacks.pop_front());
            end
        end

        wait_for_lookups();
        repeat (8) @(posedge clk);
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
